// ----- rtl/rsc_pkg.sv -----
`default_nettype none

package rsc_pkg;

  // Rotor geometry
  localparam int ROTOR_COUNT = 3;
  localparam int OFFSET_REGS = 3;
  localparam int ALPHA       = 26;

  typedef logic [4:0] letter_t;
  typedef logic [1:0] op_t;

  // Operation codes of an input word
  localparam op_t OP_LOAD = 2'd0;
  localparam op_t OP_SET  = 2'd1;
  localparam op_t OP_ENC  = 2'd2;
  localparam op_t OP_DEC  = 2'd3;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_RING_0 = 2'd0;
  localparam logic [1:0] REG_RING_1 = 2'd1;
  localparam logic [1:0] REG_RING_2 = 2'd2;

  // Character codes
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  localparam letter_t ALPHA_L = letter_t'(ALPHA);
  localparam letter_t LAST_L  = letter_t'(ALPHA - 1);

  // Input word as held in the input register
  typedef struct packed {
    op_t        operation;
    logic [7:0] char_in;
    logic [1:0] rotor_select;
    letter_t    wiring_index;
    letter_t    wiring_value;
    letter_t    start_pos_0;
    letter_t    start_pos_1;
    letter_t    start_pos_2;
  } item_t;

  // Reduce a 5-bit value to 0..25
  function automatic letter_t mod26_small(input letter_t v);
    mod26_small = (v >= ALPHA_L) ? letter_t'(v - ALPHA_L) : v;
  endfunction

  // (a + b) mod 26 for a, b in 0..25
  function automatic letter_t add_mod26(input letter_t a, input letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    add_mod26 = (s >= 6'(ALPHA)) ? letter_t'(s - 6'(ALPHA)) : letter_t'(s);
  endfunction

  // (a - b) mod 26 for a, b in 0..25
  function automatic letter_t sub_mod26(input letter_t a, input letter_t b);
    sub_mod26 = (a >= b) ? letter_t'(a - b) : letter_t'(a + ALPHA_L - b);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rsc_in_if.sv -----
`default_nettype none

interface rsc_in_if;
  logic                 valid;
  logic                 ready;
  rsc_pkg::op_t         operation;
  logic [7:0]           char_in;
  logic [1:0]           rotor_select;
  rsc_pkg::letter_t     wiring_index;
  rsc_pkg::letter_t     wiring_value;
  rsc_pkg::letter_t     start_pos_0;
  rsc_pkg::letter_t     start_pos_1;
  rsc_pkg::letter_t     start_pos_2;

  modport source (
    output valid, operation, char_in, rotor_select, wiring_index, wiring_value,
           start_pos_0, start_pos_1, start_pos_2,
    input  ready
  );

  modport sink (
    input  valid, operation, char_in, rotor_select, wiring_index, wiring_value,
           start_pos_0, start_pos_1, start_pos_2,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/rsc_out_if.sv -----
`default_nettype none

interface rsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_out;

  modport source (
    output valid, char_out,
    input  ready
  );

  modport sink (
    input  valid, char_out,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/rotor_substitution_cipher.sv -----
// Three-rotor substitution cipher without a reflector.
// in_chan carries one word per accepted valid/ready handshake: a wiring load
// (one forward entry and its inverse), a position set, or a byte to encipher
// or decipher. Load and set words give no output word; encipher and decipher
// words give exactly one char_out word on out_chan. Letters are upper-cased
// and run through the rotors with position plus ring offset mod 26, then the
// positions step like an odometer; other bytes pass unchanged, no stepping.
// A word is registered at the input, processed in one pass, and its result
// is loaded into the output register as the word leaves the input register.
// Throughput: one word per cycle unless out_chan stalls; each word reads
// the rotor state left by the word before it, updated as that word leaves
// the input register.
// The ring offsets are written over the APB port at 0x0, 0x4, 0x8.
// When out_chan stalls, the output register holds its word and the input
// register holds the next word that has a result; load and set words still
// drain. in_chan.ready drops only while both are full.
// Reset (rst, synchronous) empties both registers, zeroes positions and
// offsets; wiring entries hold garbage until loaded.
`default_nettype none

module rotor_substitution_cipher (
  input  wire logic        clk,
  input  wire logic        rst,
  rsc_in_if.sink           in_chan,
  rsc_out_if.source        out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int RC = rsc_pkg::ROTOR_COUNT;

  // Input register
  logic            s1_valid;
  rsc_pkg::item_t  s1_item;

  // Output register
  logic            out_valid;
  logic [7:0]      out_char;

  // Rotor state
  rsc_pkg::letter_t fwd [RC][rsc_pkg::ALPHA];
  rsc_pkg::letter_t inv [RC][rsc_pkg::ALPHA];
  rsc_pkg::letter_t pos [RC];
  rsc_pkg::letter_t pos_next [RC];
  rsc_pkg::letter_t ring_offset [rsc_pkg::OFFSET_REGS];

  // Datapath signals
  rsc_pkg::letter_t shift [RC];
  rsc_pkg::letter_t enc [RC+1];
  rsc_pkg::letter_t dec [RC+1];
  rsc_pkg::letter_t start_pos [RC];
  logic [7:0]       ch_up;
  logic             is_letter;
  logic             is_text;
  logic             has_result;
  logic             s1_fire;
  logic             in_accept;
  logic             cfg_write;
  rsc_pkg::letter_t res_letter;
  rsc_pkg::letter_t val26;
  logic [7:0]       result_char;

  assign pready   = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rsc_pkg::OFFSET_REGS; i++) begin
        ring_offset[i] <= '0;
      end
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        rsc_pkg::REG_RING_0: ring_offset[0] <= rsc_pkg::mod26_small(pwdata[4:0]);
        rsc_pkg::REG_RING_1: ring_offset[1] <= rsc_pkg::mod26_small(pwdata[4:0]);
        rsc_pkg::REG_RING_2: ring_offset[2] <= rsc_pkg::mod26_small(pwdata[4:0]);
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (paddr[3:2])
      rsc_pkg::REG_RING_0: prdata = {27'd0, ring_offset[0]};
      rsc_pkg::REG_RING_1: prdata = {27'd0, ring_offset[1]};
      rsc_pkg::REG_RING_2: prdata = {27'd0, ring_offset[2]};
      default:             prdata = '0;
    endcase
  end

  // Handshake: advance the input register when its word can leave
  assign is_text    = (s1_item.operation == rsc_pkg::OP_ENC) ||
                      (s1_item.operation == rsc_pkg::OP_DEC);
  assign has_result = s1_valid && is_text;
  assign s1_fire    = s1_valid && (!has_result || !out_valid || out_chan.ready);
  assign in_chan.ready = !s1_valid || s1_fire;
  assign in_accept  = in_chan.valid && in_chan.ready;

  // Capture the input word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.operation    <= in_chan.operation;
      s1_item.char_in      <= in_chan.char_in;
      s1_item.rotor_select <= in_chan.rotor_select;
      s1_item.wiring_index <= in_chan.wiring_index;
      s1_item.wiring_value <= in_chan.wiring_value;
      s1_item.start_pos_0  <= in_chan.start_pos_0;
      s1_item.start_pos_1  <= in_chan.start_pos_1;
      s1_item.start_pos_2  <= in_chan.start_pos_2;
    end
  end

  // Upper-case and classify the byte
  always_comb begin
    if (s1_item.char_in >= rsc_pkg::CHAR_LA && s1_item.char_in <= rsc_pkg::CHAR_LZ) begin
      ch_up = s1_item.char_in & rsc_pkg::CASE_MASK;
    end else begin
      ch_up = s1_item.char_in;
    end
  end
  assign is_letter = (ch_up >= rsc_pkg::CHAR_UA) && (ch_up <= rsc_pkg::CHAR_UZ);

  // Per-rotor shift: position plus ring offset
  always_comb begin
    for (int r = 0; r < RC; r++) begin
      if (r < rsc_pkg::OFFSET_REGS) begin
        shift[r] = rsc_pkg::add_mod26(pos[r], ring_offset[r]);
      end else begin
        shift[r] = pos[r];
      end
    end
  end

  // Forward pass through rotors in ascending order, inverse pass descending
  always_comb begin
    enc[0]  = rsc_pkg::letter_t'(ch_up - rsc_pkg::CHAR_UA);
    dec[RC] = rsc_pkg::letter_t'(ch_up - rsc_pkg::CHAR_UA);
    for (int r = 0; r < RC; r++) begin
      enc[r+1] = fwd[r][rsc_pkg::sub_mod26(enc[r], shift[r])];
    end
    for (int r = RC - 1; r >= 0; r--) begin
      dec[r] = rsc_pkg::add_mod26(inv[r][dec[r+1]], shift[r]);
    end
  end

  assign res_letter  = (s1_item.operation == rsc_pkg::OP_ENC) ? enc[RC] : dec[0];
  assign result_char = is_letter ? (rsc_pkg::CHAR_UA + {3'd0, res_letter}) : ch_up;

  // Odometer stepping of the positions
  always_comb begin
    logic carry;
    carry = 1'b1;
    for (int r = 0; r < RC; r++) begin
      if (!carry) begin
        pos_next[r] = pos[r];
      end else if (pos[r] == rsc_pkg::LAST_L) begin
        pos_next[r] = '0;
      end else begin
        pos_next[r] = pos[r] + 5'd1;
        carry = 1'b0;
      end
    end
  end

  // Start positions from a set word; rotors past the third start at zero
  always_comb begin
    for (int r = 0; r < RC; r++) begin
      start_pos[r] = '0;
    end
    start_pos[0] = rsc_pkg::mod26_small(s1_item.start_pos_0);
    if (RC > 1) begin
      start_pos[1 % RC] = rsc_pkg::mod26_small(s1_item.start_pos_1);
    end
    if (RC > 2) begin
      start_pos[2 % RC] = rsc_pkg::mod26_small(s1_item.start_pos_2);
    end
  end

  // Update positions as the word leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < RC; r++) begin
        pos[r] <= '0;
      end
    end else if (s1_fire) begin
      if (s1_item.operation == rsc_pkg::OP_SET) begin
        pos <= start_pos;
      end else if (is_text && is_letter) begin
        pos <= pos_next;
      end
    end
  end

  // Write one wiring entry and its inverse
  assign val26 = rsc_pkg::mod26_small(s1_item.wiring_value);

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item.operation == rsc_pkg::OP_LOAD &&
        int'(s1_item.rotor_select) < RC &&
        s1_item.wiring_index < rsc_pkg::ALPHA_L) begin
      fwd[s1_item.rotor_select][s1_item.wiring_index] <= val26;
      inv[s1_item.rotor_select][val26] <= s1_item.wiring_index;
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && has_result) begin
      out_char <= result_char;
    end
  end

  assign out_chan.valid    = out_valid;
  assign out_chan.char_out = out_char;

endmodule

`default_nettype wire

// ----- tb/sv/rotor_cipher_monitor.sv -----
// Watches both channels and the APB port, predicts every output word and
// compares it against what the block delivers.
module rotor_cipher_monitor
  import rsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  rsc_in_if                in_chan,
  rsc_out_if               out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic        pready,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output int               fail_count,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the rotor machine
  letter_t    fwd_table [ROTOR_COUNT][ALPHA];
  letter_t    inv_table [ROTOR_COUNT][ALPHA];
  letter_t    rotor_pos [ROTOR_COUNT];
  letter_t    ring_off  [ROTOR_COUNT];
  logic [7:0] expected_chars [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Step rotor 0, carry into the next rotor on each wrap
  function automatic void advance_odometer();
    for (int r = 0; r < ROTOR_COUNT; r++) begin
      if (rotor_pos[r] != LAST_L) begin
        rotor_pos[r] = rotor_pos[r] + 1'b1;
        return;
      end
      rotor_pos[r] = '0;
    end
  endfunction

  // Apply one input word to the shadow state; return 1 when it yields a char
  function automatic bit rotor_transform(input item_t w, output logic [7:0] result);
    int c;
    int k;
    int val;
    logic [7:0] ch;
    result = '0;
    case (w.operation)
      OP_LOAD: begin
        // Drop loads aimed past the last rotor or contact
        if (w.rotor_select < ROTOR_COUNT && w.wiring_index < ALPHA) begin
          val = int'(w.wiring_value) % ALPHA;
          fwd_table[w.rotor_select][w.wiring_index] = letter_t'(val);
          inv_table[w.rotor_select][val] = w.wiring_index;
        end
        return 1'b0;
      end
      OP_SET: begin
        rotor_pos[0] = letter_t'(int'(w.start_pos_0) % ALPHA);
        rotor_pos[1] = letter_t'(int'(w.start_pos_1) % ALPHA);
        rotor_pos[2] = letter_t'(int'(w.start_pos_2) % ALPHA);
        return 1'b0;
      end
      default: begin
        ch = w.char_in;
        if (ch >= CHAR_LA && ch <= CHAR_LZ) ch = ch & CASE_MASK;
        // Only letters go through the rotors and step them
        if (ch >= CHAR_UA && ch <= CHAR_UZ) begin
          c = int'(ch - CHAR_UA);
          if (w.operation == OP_ENC) begin
            for (int r = 0; r < ROTOR_COUNT; r++) begin
              k = (c + 2 * ALPHA - int'(rotor_pos[r]) - int'(ring_off[r])) % ALPHA;
              c = int'(fwd_table[r][k]);
            end
          end else begin
            for (int r = ROTOR_COUNT - 1; r >= 0; r--) begin
              c = (int'(inv_table[r][c]) + int'(rotor_pos[r]) + int'(ring_off[r])) % ALPHA;
            end
          end
          ch = 8'(c) + CHAR_UA;
          advance_odometer();
        end
        result = ch;
        return 1'b1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    item_t      w;
    logic [7:0] want;
    logic [7:0] ch;
    if (rst) begin
      // Clear positions, offsets and anything in flight
      for (int r = 0; r < ROTOR_COUNT; r++) begin
        rotor_pos[r] = '0;
        ring_off[r]  = '0;
      end
      expected_chars.delete();
    end else begin
      // Track ring offset writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_RING_0: ring_off[0] = letter_t'(int'(pwdata[4:0]) % ALPHA);
          REG_RING_1: ring_off[1] = letter_t'(int'(pwdata[4:0]) % ALPHA);
          REG_RING_2: ring_off[2] = letter_t'(int'(pwdata[4:0]) % ALPHA);
          default: ;
        endcase
      end
      // Compare a delivered word against the oldest prediction
      if (out_chan.valid && out_chan.ready) begin
        if (expected_chars.size() == 0) begin
          $error("char_out: expected none, actual 0x%02h", out_chan.char_out);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_chan.char_out !== want) begin
            $error("char_out: expected 0x%02h, actual 0x%02h", want, out_chan.char_out);
            fail_count++;
          end
        end
      end
      // Predict from an accepted input word
      if (in_chan.valid && in_chan.ready) begin
        w.operation    = in_chan.operation;
        w.char_in      = in_chan.char_in;
        w.rotor_select = in_chan.rotor_select;
        w.wiring_index = in_chan.wiring_index;
        w.wiring_value = in_chan.wiring_value;
        w.start_pos_0  = in_chan.start_pos_0;
        w.start_pos_1  = in_chan.start_pos_1;
        w.start_pos_2  = in_chan.start_pos_2;
        if (rotor_transform(w, ch)) expected_chars.push_back(ch);
      end
    end
    pending = expected_chars.size();
  end

endmodule

// ----- tb/sv/tb_rotor_substitution_cipher.sv -----
module tb_rotor_substitution_cipher;
  import rsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          stall_req = 1'b0;
  int          stall_left = 0;
  rx_mode_e    rx_mode = RX_OPEN;
  int          mode_left = 0;
  int          rx_tick = 0;

  rsc_in_if  in_chan ();
  rsc_out_if out_chan ();

  rotor_substitution_cipher dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rotor_cipher_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side: long hold-off on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (stall_req) begin
      stall_left = HOLD_CYCLES;
      stall_req  = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_chan.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   out_chan.ready <= 1'b1;
        RX_COIN:   out_chan.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_chan.ready <= (rx_tick % 4 == 0);
        default:   out_chan.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Random background so that unused fields toggle too
  function automatic item_t noise_word(op_t op);
    item_t w;
    w.operation    = op;
    w.char_in      = 8'($urandom);
    w.rotor_select = 2'($urandom);
    w.wiring_index = 5'($urandom);
    w.wiring_value = 5'($urandom);
    w.start_pos_0  = 5'($urandom);
    w.start_pos_1  = 5'($urandom);
    w.start_pos_2  = 5'($urandom);
    return w;
  endfunction

  // Mostly letters of either case, some arbitrary bytes
  function automatic logic [7:0] pick_char();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 8'(CHAR_UA + $urandom_range(0, 25));
    if (roll < 75) return 8'(CHAR_LA + $urandom_range(0, 25));
    return 8'($urandom_range(0, 255));
  endfunction

  // Favor positions next to the wrap so carries happen often
  function automatic letter_t pick_pos();
    case ($urandom_range(0, 3))
      0: return LAST_L;
      1: return LAST_L - 1'b1;
      default: return letter_t'($urandom_range(0, 31));
    endcase
  endfunction

  // Offer one word in bursts with random gaps, hold until accepted
  task automatic send_word(item_t w);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_chan.operation    <= w.operation;
    in_chan.char_in      <= w.char_in;
    in_chan.rotor_select <= w.rotor_select;
    in_chan.wiring_index <= w.wiring_index;
    in_chan.wiring_value <= w.wiring_value;
    in_chan.start_pos_0  <= w.start_pos_0;
    in_chan.start_pos_1  <= w.start_pos_1;
    in_chan.start_pos_2  <= w.start_pos_2;
    in_chan.valid        <= 1'b1;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_text(op_t op, logic [7:0] ch);
    item_t w;
    w         = noise_word(op);
    w.char_in = ch;
    send_word(w);
  endtask

  task automatic send_set(letter_t p0, letter_t p1, letter_t p2);
    item_t w;
    w             = noise_word(OP_SET);
    w.start_pos_0 = p0;
    w.start_pos_1 = p1;
    w.start_pos_2 = p2;
    send_word(w);
  endtask

  task automatic send_load(logic [1:0] sel, letter_t idx, letter_t val);
    item_t w;
    w              = noise_word(OP_LOAD);
    w.rotor_select = sel;
    w.wiring_index = idx;
    w.wiring_value = val;
    send_word(w);
  endtask

  // Load a fresh random permutation into one rotor
  task automatic load_rotor(int r);
    int perm [ALPHA];
    int j;
    int t;
    for (int i = 0; i < ALPHA; i++) perm[i] = i;
    for (int i = ALPHA - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      t       = perm[i];
      perm[i] = perm[j];
      perm[j] = t;
    end
    for (int i = 0; i < ALPHA; i++) send_load(2'(r), letter_t'(i), letter_t'(perm[i]));
  endtask

  // Drop valid, wait for every predicted word, then let the pipe settle
  task automatic wait_drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready
  task automatic write_ring(logic [1:0] reg_idx, logic [4:0] value);
    @(negedge clk);
    in_chan.valid <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= {27'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly text, some position sets and raw loads
  task automatic random_word();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) send_text(OP_ENC, pick_char());
    else if (roll < 70) send_text(OP_DEC, pick_char());
    else if (roll < 80) send_set(pick_pos(), pick_pos(), pick_pos());
    else send_word(noise_word(OP_LOAD));
  endtask

  initial begin : stimulus
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_chan.valid        = 1'b0;
    in_chan.operation    = OP_LOAD;
    in_chan.char_in      = '0;
    in_chan.rotor_select = '0;
    in_chan.wiring_index = '0;
    in_chan.wiring_value = '0;
    in_chan.start_pos_0  = '0;
    in_chan.start_pos_1  = '0;
    in_chan.start_pos_2  = '0;
    out_chan.ready       = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Reset offsets, then wire every rotor before any text
    write_ring(REG_RING_0, 5'd0);
    write_ring(REG_RING_1, 5'd0);
    write_ring(REG_RING_2, 5'd0);
    for (int r = 0; r < ROTOR_COUNT; r++) load_rotor(r);

    // Full odometer wrap, case folding and non-letter bytes
    send_set(LAST_L, LAST_L, LAST_L);
    send_text(OP_ENC, CHAR_UA);
    send_text(OP_ENC, CHAR_LZ);
    send_text(OP_DEC, CHAR_UZ);
    send_text(OP_DEC, CHAR_LA);
    send_text(OP_ENC, 8'h00);
    send_text(OP_ENC, 8'hFF);
    send_text(OP_ENC, CHAR_UA - 8'd1);
    send_text(OP_DEC, CHAR_UZ + 8'd1);
    send_text(OP_ENC, CHAR_LA - 8'd1);
    send_text(OP_DEC, CHAR_LZ + 8'd1);
    send_text(OP_ENC, CHAR_UA | 8'h80);
    send_text(OP_DEC, CHAR_LA | 8'h80);
    // Out-of-range positions fold back into the alphabet
    send_set(5'd31, 5'd26, 5'd30);
    send_text(OP_ENC, CHAR_UA + 8'd12);
    send_text(OP_DEC, CHAR_LA + 8'd12);
    // Ignored loads, then a value that needs folding and breaks the permutation
    send_load(2'd3, 5'd0, 5'd5);
    send_load(2'd1, 5'd31, 5'd7);
    send_load(2'd2, 5'd26, 5'd9);
    send_load(2'd0, LAST_L, 5'd31);
    // Carry through rotor 1 into rotor 2
    send_set(LAST_L - 1'b1, LAST_L, 5'd0);
    send_text(OP_ENC, CHAR_UA + 8'd16);
    send_text(OP_ENC, CHAR_UA + 8'd17);
    send_text(OP_DEC, CHAR_UA + 8'd10);

    for (int ph = 0; ph < 4; ph++) begin
      wait_drain();
      case (ph)
        0: begin
          write_ring(REG_RING_0, 5'd25);
          write_ring(REG_RING_1, 5'd25);
          write_ring(REG_RING_2, 5'd25);
        end
        1: begin
          write_ring(REG_RING_0, 5'd31);
          write_ring(REG_RING_1, 5'd26);
          write_ring(REG_RING_2, 5'd29);
        end
        2: begin
          write_ring(REG_RING_0, 5'($urandom_range(0, 31)));
          write_ring(REG_RING_1, 5'($urandom_range(0, 31)));
          write_ring(REG_RING_2, 5'($urandom_range(0, 31)));
        end
        default: begin
          write_ring(REG_RING_0, 5'd0);
          write_ring(REG_RING_1, 5'd13);
          write_ring(REG_RING_2, 5'($urandom_range(0, 31)));
        end
      endcase
      load_rotor(ph % ROTOR_COUNT);
      for (int n = 0; n < 55; n++) begin
        // Hold the output off while letters keep coming, to back up the input
        if (ph == 1 && n == 40) begin
          stall_req = 1'b1;
          repeat (24) send_text(OP_ENC, 8'(CHAR_UA + $urandom_range(0, 25)));
        end
        // Pause the sender until the block is empty
        if (ph == 2 && n == 27) wait_drain();
        random_word();
      end
    end

    wait_drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
